// File: hw/rtl/hpo_pkg.sv
package hpo_pkg;

	localparam int PHASE_BITS       = 32;
	localparam int SINE_ADDR_BITS   = 10;
	localparam int SAMPLE_FRAC_BITS = 15;

	localparam int POS_W     = 24;
	localparam int INC_W     = 31;
	localparam int TIMBRE_W  = 2;
	localparam int OUT_W     = SAMPLE_FRAC_BITS + 2;

	localparam int QTR_BITS  = SINE_ADDR_BITS - 2;
	localparam int QUARTER   = 1 << QTR_BITS;
	localparam int IDX_W     = QTR_BITS + 1;
	localparam int TAB_W     = SAMPLE_FRAC_BITS + 1;
	localparam int SINE_W    = TAB_W + 1;

	localparam int NUM_HARM    = 8;
	localparam int NUM_TIMBRE  = 1 << TIMBRE_W;
	localparam int WEIGHT_W    = 17;
	localparam int WEIGHT_FRAC = 16;
	localparam int PROD_W      = SINE_W + WEIGHT_W + 1;
	localparam int ACC_W       = PROD_W + $clog2(NUM_HARM);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic REG_START_INC    = 1'b0;
	localparam logic REG_START_TIMBRE = 1'b1;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [WEIGHT_W-1:0] MIX_WEIGHT [NUM_TIMBRE][NUM_HARM] = '{
		'{17'd65536, 17'd0,    17'd0,   17'd0, 17'd0,     17'd0,   17'd0,   17'd0},
		'{17'd65536, 17'd6554, 17'd0,   17'd0, 17'd6554,  17'd0,   17'd0,   17'd0},
		'{17'd54381, 17'd1101, 17'd937, 17'd0, 17'd0,     17'd0,   17'd0,   17'd0},
		'{17'd65536, 17'd0,    17'd0,   17'd0, 17'd13107, 17'd655, 17'd655, 17'd13107}
	};

	typedef logic [TAB_W-1:0] sine_tab_t [QUARTER+1];

	typedef struct packed {
		logic [PHASE_BITS-1:0] phase;
		logic [TIMBRE_W-1:0]   timbre;
	} hpo_item_t;

	typedef struct packed {
		logic                inc_wr;
		logic                timbre_wr;
		logic [INC_W-1:0]    inc;
		logic [TIMBRE_W-1:0] timbre;
	} hpo_cfg_t;

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int k = 0; k <= QUARTER; k++) begin
			x  = (64'(k) * HALF_PI_Q30 + 64'(QUARTER / 2)) / QUARTER;
			x2 = (x * x) >> 30;
			s  = x;
			t  = ((x * x2) >> 30) / 6;
			s  = s - t;
			t  = ((t * x2) >> 30) / 20;
			s  = s + t;
			t  = ((t * x2) >> 30) / 42;
			s  = s - t;
			t  = ((t * x2) >> 30) / 72;
			s  = s + t;
			t  = ((t * x2) >> 30) / 110;
			s  = s - t;
			t  = ((t * x2) >> 30) / 156;
			s  = s + t;
			s  = (s + (64'd1 << (29 - SAMPLE_FRAC_BITS))) >> (30 - SAMPLE_FRAC_BITS);
			tab[k] = TAB_W'(s);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// File: hw/rtl/hpo_cfg.sv
module hpo_cfg import hpo_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output hpo_cfg_t              cfg
);

	logic [INC_W-1:0]    start_increment_q;
	logic [TIMBRE_W-1:0] start_timbre_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_increment_q <= '0;
			start_timbre_q    <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_START_INC:    start_increment_q <= pwdata[INC_W-1:0];
				REG_START_TIMBRE: start_timbre_q    <= pwdata[TIMBRE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.inc_wr    = wr_en && (paddr[2] == REG_START_INC);
		cfg.timbre_wr = wr_en && (paddr[2] == REG_START_TIMBRE);
		cfg.inc       = pwdata[INC_W-1:0];
		cfg.timbre    = pwdata[TIMBRE_W-1:0];
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (paddr[2])
				REG_START_INC:    prdata = CFG_DATA_W'(start_increment_q);
				REG_START_TIMBRE: prdata = CFG_DATA_W'(start_timbre_q);
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/hpo_front.sv
module hpo_front import hpo_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  hpo_cfg_t            cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [POS_W-1:0]    loop_position,
	input  logic [POS_W-1:0]    switch_position,
	input  logic [INC_W-1:0]    pending_increment,
	input  logic [TIMBRE_W-1:0] pending_timbre,
	input  logic                fifo_full,
	output logic                push,
	output hpo_item_t           push_item
);

	logic [PHASE_BITS-1:0] phase_q;
	logic [INC_W-1:0]      step_q;
	logic [TIMBRE_W-1:0]   timbre_q;
	logic                  match;
	logic [INC_W-1:0]      step_eff;
	logic [TIMBRE_W-1:0]   timbre_eff;
	logic [PHASE_BITS-1:0] phase_next;

	assign in_stall   = fifo_full;
	assign push       = in_valid & ~fifo_full;
	assign match      = (loop_position == switch_position);
	assign step_eff   = match ? pending_increment : step_q;
	assign timbre_eff = match ? pending_timbre : timbre_q;
	assign phase_next = phase_q + PHASE_BITS'(step_eff);

	assign push_item.phase  = phase_next;
	assign push_item.timbre = timbre_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			step_q   <= '0;
			timbre_q <= '0;
		end else if (cfg.inc_wr || cfg.timbre_wr) begin
			phase_q <= '0;
			if (cfg.inc_wr)
				step_q <= cfg.inc;
			if (cfg.timbre_wr)
				timbre_q <= cfg.timbre;
		end else if (push) begin
			phase_q  <= phase_next;
			step_q   <= step_eff;
			timbre_q <= timbre_eff;
		end
	end

	a_cfg_restarts_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.inc_wr || cfg.timbre_wr) |=> (phase_q == '0))
		else $error("phase not restarted by register write");

endmodule

// File: hw/rtl/hpo_fifo.sv
module hpo_fifo import hpo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  hpo_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output hpo_item_t head
);

	hpo_item_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != FIFO_CNT_W'(FIFO_DEPTH)) |->
		(FIFO_PTR_W'(count_q) == FIFO_PTR_W'(wr_ptr_q - rd_ptr_q)))
		else $error("queue pointers disagree with count");

endmodule

// File: hw/rtl/hpo_back.sv
module hpo_back import hpo_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fifo_empty,
	input  hpo_item_t               fifo_head,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] sample
);

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(1) <<< (WEIGHT_FRAC - 1);

	logic                          adv;
	logic                          valid_s1, valid_s2, valid_s3, valid_s4;
	logic                          out_valid_q;
	logic [SINE_ADDR_BITS-1:0]     addr_s1 [NUM_HARM];
	logic [TIMBRE_W-1:0]           timbre_s1, timbre_s2;
	logic signed [SINE_W-1:0]      sine_s2 [NUM_HARM];
	logic signed [PROD_W-1:0]      prod_s3 [NUM_HARM];
	logic signed [ACC_W-1:0]       psum_s4 [NUM_HARM/2];
	logic signed [OUT_W-1:0]       sample_q;

	logic [SINE_ADDR_BITS-1:0]     addr_d [NUM_HARM];
	logic signed [SINE_W-1:0]      sine_d [NUM_HARM];
	logic signed [PROD_W-1:0]      prod_d [NUM_HARM];
	logic signed [ACC_W-1:0]       total;
	logic signed [ACC_W-1:0]       scaled;
	logic signed [OUT_W-1:0]       sample_d;

	assign adv       = ~out_valid_q | ~out_stall;
	assign pop       = adv & ~fifo_empty;
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	for (genvar h = 0; h < NUM_HARM; h++) begin : g_harm
		logic [PHASE_BITS-1:0]   hphase;
		logic [1:0]              quad;
		logic [QTR_BITS-1:0]     ofs;
		logic [IDX_W-1:0]        idx;
		logic [TAB_W-1:0]        mag;
		logic signed [WEIGHT_W:0] wt;

		assign hphase    = PHASE_BITS'(fifo_head.phase * PHASE_BITS'(h + 1));
		assign addr_d[h] = hphase[PHASE_BITS-1 -: SINE_ADDR_BITS];

		assign quad = addr_s1[h][SINE_ADDR_BITS-1 -: 2];
		assign ofs  = addr_s1[h][QTR_BITS-1:0];
		assign idx  = quad[0] ? (IDX_W'(QUARTER) - IDX_W'(ofs)) : IDX_W'(ofs);
		assign mag  = SINE_TAB[idx];
		assign sine_d[h] = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

		assign wt        = $signed({1'b0, MIX_WEIGHT[timbre_s2][h]});
		assign prod_d[h] = sine_s2[h] * wt;
	end

	always_comb begin
		total = ROUND;
		for (int j = 0; j < NUM_HARM / 2; j++)
			total = total + psum_s4[j];
		scaled = total >>> WEIGHT_FRAC;
		if (scaled > SAT_HI)
			sample_d = OUT_W'(SAT_HI);
		else if (scaled < SAT_LO)
			sample_d = OUT_W'(SAT_LO);
		else
			sample_d = OUT_W'(scaled);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= ~fifo_empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			timbre_s1 <= fifo_head.timbre;
			timbre_s2 <= timbre_s1;
			for (int h = 0; h < NUM_HARM; h++) begin
				addr_s1[h] <= addr_d[h];
				sine_s2[h] <= sine_d[h];
				prod_s3[h] <= prod_d[h];
			end
			for (int j = 0; j < NUM_HARM / 2; j++)
				psum_s4[j] <= ACC_W'(prod_s3[2*j]) + ACC_W'(prod_s3[2*j+1]);
			sample_q <= sample_d;
		end
	end

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> ($stable(valid_s4) && $stable(sample_q)))
		else $error("pipeline moved while output stalled");

	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !pop)
		else $error("queue popped while output stalled");

endmodule

// File: hw/rtl/harmonic_phase_oscillator.sv
// channel   signals                                         direction
// input     in_valid/in_stall, loop_position,               in (stall out)
//           switch_position, pending_increment,
//           pending_timbre
// output    out_valid/out_stall, sample                     out (stall in)
// config    psel/penable/pwrite/paddr/pwdata/prdata/pready  APB slave
//
// One transaction per cycle sustained in both directions while neither side stalls.
// On the way from input acceptance to sample valid, the queue is written at the
// accepting edge, then five registers of synthesis pipeline follow.
// in_stall rises only when the queue is full; the queue absorbs output stalls.
// arst_n clears the phase, step, timbre, registers and all valid flags.
module harmonic_phase_oscillator import hpo_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [CFG_ADDR_W-1:0]   paddr,
	input  logic [CFG_DATA_W-1:0]   pwdata,
	output logic [CFG_DATA_W-1:0]   prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [POS_W-1:0]        loop_position,
	input  logic [POS_W-1:0]        switch_position,
	input  logic [INC_W-1:0]        pending_increment,
	input  logic [TIMBRE_W-1:0]     pending_timbre,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] sample
);

	hpo_cfg_t  cfg;
	hpo_item_t push_item;
	hpo_item_t fifo_head;
	logic      push;
	logic      fifo_full;
	logic      fifo_empty;
	logic      pop;

	hpo_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hpo_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.loop_position     (loop_position),
		.switch_position   (switch_position),
		.pending_increment (pending_increment),
		.pending_timbre    (pending_timbre),
		.fifo_full         (fifo_full),
		.push              (push),
		.push_item         (push_item)
	);

	hpo_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (fifo_full),
		.pop       (pop),
		.empty     (fifo_empty),
		.head      (fifo_head)
	);

	hpo_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.fifo_head  (fifo_head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample     (sample)
	);

endmodule
